// File: hw/rtl/etm_pkg.sv
// Shared constants for the exponential tone-mapping pixel pipeline.
// Used by every module in hw/rtl; depends on nothing else.
`default_nettype none
package etm_pkg;

	// Q30 constants for log2(e) and ln(2).
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	// Series length and pipeline depths.
	localparam int unsigned TAYLOR_TERMS = 12;
	localparam int unsigned EXP_LAT = 3 + 2 * TAYLOR_TERMS + 1;
	localparam int unsigned SQRT_BITS = 25;
	localparam int unsigned LANE_LAT = EXP_LAT + 1 + SQRT_BITS;

	// Exposure register value after reset (10.0 in Q8.8).
	localparam logic [15:0] GAIN_RESET = 16'd2560;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

endpackage
`default_nettype wire

// File: hw/rtl/etm_exp.sv
// Fixed-point exp(-gain*v) in Q30 for one channel, fully pipelined.
// Depends on etm_pkg. The pipeline advances when en is high.
`default_nettype none
module etm_exp (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] raw,
	input  wire logic [15:0] gain,
	output logic [30:0]      e
);
	import etm_pkg::*;

	logic        zero_s1;
	logic [46:0] x_s1;
	logic        zero_s2, big_s2;
	logic [29:0] y_s2;
	logic        zero_s3, big_s3;
	logic [29:0] z_s3;
	logic [5:0]  n_s3;
	logic [59:0] prod2;
	logic [53:0] prod3;

	// Scale by exposure; flag non-positive input or zero gain.
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1 <= raw[31] | (raw == 32'd0) | (gain == 16'd0);
			x_s1    <= 47'(raw[30:0]) * 47'(gain);
		end
	end

	// Convert to a base-2 exponent y = x*log2(e).
	assign prod2 = 60'(x_s1[28:0]) * 60'(LOG2E_Q30);
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s2 <= zero_s1;
			big_s2  <= |x_s1[46:29];
			y_s2    <= prod2[59:30];
		end
	end

	// Split y; the fraction turns back into a natural exponent z.
	assign prod3 = 54'(y_s2[23:0]) * 54'(LN2_Q30);
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s3 <= zero_s2;
			big_s3  <= big_s2 | (y_s2[29:24] > 6'd30);
			z_s3    <= prod3[53:24];
			n_s3    <= y_s2[29:24];
		end
	end

	// Taylor series chain, two stages per term.
	logic [29:0]        zb    [0:TAYLOR_TERMS];
	logic [5:0]         nb    [0:TAYLOR_TERMS];
	logic               zerob [0:TAYLOR_TERMS];
	logic               bigb  [0:TAYLOR_TERMS];
	logic signed [33:0] sumb  [0:TAYLOR_TERMS];
	logic [30:0]        termb [0:TAYLOR_TERMS];

	assign zb[0]    = z_s3;
	assign nb[0]    = n_s3;
	assign zerob[0] = zero_s3;
	assign bigb[0]  = big_s3;
	assign sumb[0]  = 34'(ONE_Q30);
	assign termb[0] = ONE_Q30;

	for (genvar k = 1; k <= TAYLOR_TERMS; k++) begin : g_term
		localparam int unsigned K = k;
		localparam int unsigned L = $clog2(K);
		localparam int unsigned S = 30 + L;
		localparam logic [63:0] M_WIDE = ((64'd1 << S) + 64'(K) - 64'd1) / 64'(K);
		localparam logic [31:0] M_K = M_WIDE[31:0];

		logic [59:0]        prod_a;
		logic [61:0]        prod_b;
		logic [29:0]        p_a;
		logic [29:0]        z_a;
		logic [5:0]         n_a;
		logic               zero_a, big_a;
		logic signed [33:0] sum_a;
		logic [30:0]        t_new;

		// Multiply the previous term by z.
		assign prod_a = 60'(termb[k-1]) * 60'(zb[k-1]);
		always_ff @(posedge clk) begin
			if (en) begin
				p_a    <= prod_a[59:30];
				z_a    <= zb[k-1];
				n_a    <= nb[k-1];
				zero_a <= zerob[k-1];
				big_a  <= bigb[k-1];
				sum_a  <= sumb[k-1];
			end
		end

		// Divide by k through an exact reciprocal multiply, then accumulate.
		assign prod_b = 62'(p_a) * 62'(M_K);
		assign t_new  = 31'(prod_b >> S);
		always_ff @(posedge clk) begin
			if (en) begin
				termb[k] <= t_new;
				zb[k]    <= z_a;
				nb[k]    <= n_a;
				zerob[k] <= zero_a;
				bigb[k]  <= big_a;
				if ((K % 2) == 1) begin
					sumb[k] <= sum_a - 34'(t_new);
				end else begin
					sumb[k] <= sum_a + 34'(t_new);
				end
			end
		end
	end

	// Clamp the series and apply the integer part as a right shift.
	logic [30:0] clamped;
	logic [30:0] e_q;
	always_comb begin
		if (sumb[TAYLOR_TERMS] < 0) begin
			clamped = 31'd0;
		end else if (sumb[TAYLOR_TERMS] > 34'(ONE_Q30)) begin
			clamped = ONE_Q30;
		end else begin
			clamped = sumb[TAYLOR_TERMS][30:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (zerob[TAYLOR_TERMS]) begin
				e_q <= ONE_Q30;
			end else if (bigb[TAYLOR_TERMS]) begin
				e_q <= 31'd0;
			end else begin
				e_q <= clamped >> nb[TAYLOR_TERMS][4:0];
			end
		end
	end

	assign e = e_q;
endmodule
`default_nettype wire

// File: hw/rtl/etm_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on etm_pkg. The pipeline advances when en is high.
`default_nettype none
module etm_sqrt (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [48:0] v,
	output logic [24:0]      root
);
	import etm_pkg::*;

	logic [24:0] r_a   [0:SQRT_BITS];
	logic [49:0] rem_a [0:SQRT_BITS];

	assign r_a[0]   = 25'd0;
	assign rem_a[0] = 50'(v);

	// Each stage tries one bit, from the top bit down.
	for (genvar i = 0; i < SQRT_BITS; i++) begin : g_bit
		localparam int unsigned B = SQRT_BITS - 1 - i;
		logic [49:0] inc;
		assign inc = (50'(r_a[i]) << (B + 1)) + (50'd1 << (2 * B));
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_a[i] >= inc) begin
					rem_a[i+1] <= rem_a[i] - inc;
					r_a[i+1]   <= r_a[i] | (25'd1 << B);
				end else begin
					rem_a[i+1] <= rem_a[i];
					r_a[i+1]   <= r_a[i];
				end
			end
		end
	end

	assign root = r_a[SQRT_BITS];
endmodule
`default_nettype wire

// File: hw/rtl/etm_lane.sv
// One color channel: exposure, exp(-x), 1-exp, square root and byte scaling.
// Depends on etm_pkg, etm_exp and etm_sqrt.
`default_nettype none
module etm_lane (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] raw,
	input  wire logic [15:0] gain,
	output logic [7:0]       byte_out
);
	import etm_pkg::*;

	logic [30:0] e;
	logic [30:0] t_s;
	logic [24:0] root;
	logic [32:0] scaled;

	etm_exp u_exp (
		.clk (clk),
		.en  (en),
		.raw (raw),
		.gain(gain),
		.e   (e)
	);

	// t = 1 - exp(-x) in Q30.
	always_ff @(posedge clk) begin
		if (en) begin
			t_s <= ONE_Q30 - e;
		end
	end

	etm_sqrt u_sqrt (
		.clk (clk),
		.en  (en),
		.v   ({t_s, 18'd0}),
		.root(root)
	);

	// Scale the Q24 root to a byte and saturate.
	assign scaled   = 33'(root) * 33'd255;
	assign byte_out = (scaled[32:24] > 9'd255) ? 8'd255 : scaled[31:24];
endmodule
`default_nettype wire

// File: hw/rtl/exponential_tonemap_pixel_top.sv
// Top level of the exponential tone-mapping pixel block: three channel lanes,
// exposure register, flow control and the BGRA output register.
// Depends on etm_pkg and etm_lane.
//
// Takes one HDR pixel per clock (three signed Q16.16 channels) and returns one
// BGRA pixel per clock, both while the output is not stalled; alpha is 255. Each
// channel runs in its own lane: exposure multiply, a 12-term series for exp(-x),
// a 25-stage square root and byte scaling. The whole pipeline advances together,
// so it holds when the output request is stalled; s_tready is high whenever the
// output register is empty or being taken. The exposure gain is to be written
// through cfg_valid/cfg_data only while idle; the block itself does not enforce it.
`default_nettype none
module exponential_tonemap_pixel_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// red_in [31:0], green_in [63:32], blue_in [95:64]
	input  wire logic [95:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// blue_out [7:0], green_out [15:8], red_out [23:16], alpha_out [31:24]
	output logic [31:0]      m_tdata
);
	import etm_pkg::*;

	logic [15:0] gain_q;
	logic        en;
	logic        vld_q [0:LANE_LAT-1];
	logic        out_vld_q;
	logic [31:0] out_data_q;
	logic [7:0]  red_b, green_b, blue_b;

	// Exposure register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_valid) begin
			gain_q <= cfg_data;
		end
	end

	// The pipeline moves when the output register can take a new result.
	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;

	etm_lane u_red (
		.clk(clk), .en(en), .raw(s_tdata[31:0]), .gain(gain_q), .byte_out(red_b)
	);
	etm_lane u_green (
		.clk(clk), .en(en), .raw(s_tdata[63:32]), .gain(gain_q), .byte_out(green_b)
	);
	etm_lane u_blue (
		.clk(clk), .en(en), .raw(s_tdata[95:64]), .gain(gain_q), .byte_out(blue_b)
	);

	// Valid bits that follow the lane stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANE_LAT; i++) begin
				vld_q[i] <= 1'b0;
			end
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_q[0] <= s_tvalid;
			for (int i = 1; i < LANE_LAT; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
			out_vld_q <= vld_q[LANE_LAT-1];
		end
	end

	// Merge the lanes into one BGRA word.
	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= {ALPHA_OPAQUE, red_b, green_b, blue_b};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// Testbench for exponential_tonemap_pixel_top: streams HDR pixels, predicts the BGRA bytes
// in fixed point and compares every returned pixel. Depends on etm_pkg and the block's RTL.
`default_nettype none
module tb;
	import etm_pkg::*;

	typedef struct packed {
		logic [31:0] blue;
		logic [31:0] green;
		logic [31:0] red;
	} pixel_t;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} bgra_t;

	localparam int unsigned PIPE_DRAIN = LANE_LAT + 20;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;

	logic [15:0] gain_model;
	bgra_t       pixel_queue[$];
	int          fail_count;
	bit          calm;
	int          stall_left;

	exponential_tonemap_pixel_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Integer square root, bit by bit.
	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Tone map one channel: exposure, 1 - exp(-x), square root, byte scale.
	function automatic logic [7:0] tonemap_channel(input logic [31:0] radiance);
		logic [63:0] x, y, n, f, z, term, e, t, s, b;
		longint sum;
		if (radiance[31] || radiance == 0 || gain_model == 0) return 8'd0;
		x = {32'd0, radiance} * gain_model;
		e = 0;
		if (x < (64'd32 << 24)) begin
			y = (x * 64'(LOG2E_Q30)) >> 30;
			n = y >> 24;
			f = y & 64'hFFFFFF;
			if (n <= 30) begin
				z = (f * 64'(LN2_Q30)) >> 24;
				term = 64'(ONE_Q30);
				sum = longint'(ONE_Q30);
				for (int k = 1; k <= TAYLOR_TERMS; k++) begin
					term = ((term * z) >> 30) / k;
					if (k % 2 == 1) sum = sum - longint'(term);
					else sum = sum + longint'(term);
				end
				if (sum < 0) sum = 0;
				if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
				e = 64'(sum) >> n;
			end
		end
		t = 64'(ONE_Q30) - e;
		s = int_sqrt(t << 18);
		b = (64'd255 * s) >> 24;
		if (b > 255) b = 255;
		return b[7:0];
	endfunction

	function automatic bgra_t predict_pixel(input pixel_t px);
		bgra_t o;
		o.blue = tonemap_channel(px.blue);
		o.green = tonemap_channel(px.green);
		o.red = tonemap_channel(px.red);
		o.alpha = ALPHA_OPAQUE;
		return o;
	endfunction

	function automatic logic [31:0] rand_radiance();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 32'h0000_FFFF);
			2: return $urandom_range(0, 32'h0004_0000);
			3: return $urandom_range(0, 32'h0000_0FFF);
			4: return {1'b1, 31'($urandom)};
			default: return $urandom_range(0, 32'h0010_0000);
		endcase
	endfunction

	task automatic write_gain(input logic [15:0] g);
		cfg_data <= g;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		gain_model = g;
	endtask

	task automatic wait_idle();
		while (pixel_queue.size() != 0) @(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	// Send one request, optionally with a typed-in expected result.
	task automatic send_pixel(input pixel_t px, input bit has_fixed, input bgra_t fixed);
		bgra_t exp_px;
		exp_px = predict_pixel(px);
		if (has_fixed && exp_px != fixed) begin
			$error("directed row mismatch: table %h predictor %h", fixed, exp_px);
			fail_count++;
		end
		if (!calm && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tdata <= px;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pixel_queue.push_back(has_fixed ? fixed : exp_px);
	endtask

	// Result sink with random stall bursts.
	always @(posedge clk) begin
		if (arst_n) begin
			if (calm) begin
				stall_left = 0;
				m_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left = stall_left - 1;
				if (stall_left == 0) m_tready <= 1'b1;
			end else if ($urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 15);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Compare each returned pixel with the oldest expectation.
	always @(posedge clk) begin
		bgra_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pixel_queue.size() == 0) begin
				$error("unexpected result %h", got);
				fail_count++;
			end else begin
				want = pixel_queue.pop_front();
				if (got.blue != want.blue) begin
					$error("blue_out expected %0d actual %0d", want.blue, got.blue);
					fail_count++;
				end
				if (got.green != want.green) begin
					$error("green_out expected %0d actual %0d", want.green, got.green);
					fail_count++;
				end
				if (got.red != want.red) begin
					$error("red_out expected %0d actual %0d", want.red, got.red);
					fail_count++;
				end
				if (got.alpha != want.alpha) begin
					$error("alpha_out expected %0d actual %0d", want.alpha, got.alpha);
					fail_count++;
				end
			end
		end
	end

	typedef struct {
		pixel_t px;
		bit     has_fixed;
		bgra_t  fixed;
	} stim_row_t;

	localparam bgra_t BLACK = {ALPHA_OPAQUE, 24'h000000};
	localparam bgra_t WHITE = {ALPHA_OPAQUE, 24'hFFFFFF};

	initial begin
		stim_row_t rows[$];
		pixel_t px;
		logic [15:0] gains[$];
		fail_count = 0;
		calm = 1'b0;
		stall_left = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		gain_model = GAIN_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows at the reset gain: zero, negative, huge, and mixed values.
		rows.push_back('{'{32'd0, 32'd0, 32'd0}, 1, BLACK});
		rows.push_back('{'{32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000}, 1, BLACK});
		rows.push_back('{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1, WHITE});
		rows.push_back('{'{32'h0010_0000, 32'h0040_0000, 32'h0100_0000}, 1, WHITE});
		rows.push_back('{'{32'd1, 32'd2, 32'd3}, 0, BLACK});
		rows.push_back('{'{32'h0000_1000, 32'h0000_8000, 32'h0001_0000}, 0, BLACK});
		rows.push_back('{'{32'h0000_0100, 32'h0000_0333, 32'h0000_3333}, 0, BLACK});
		rows.push_back('{'{32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_CCCC}, 0, BLACK});
		rows.push_back('{'{32'h0000_6666, 32'h0000_2000, 32'h0000_0800}, 0, BLACK});
		foreach (rows[i]) send_pixel(rows[i].px, rows[i].has_fixed, rows[i].fixed);
		s_tvalid <= 1'b0;

		// Gain sweep including both extremes; zero gain gives black.
		gains = '{16'd0, 16'hFFFF, 16'd1, 16'd256, 16'd2560};
		foreach (gains[g]) begin
			wait_idle();
			write_gain(gains[g]);
			px = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h0000_0001};
			send_pixel(px, gains[g] == 0, BLACK);
			for (int i = 0; i < 60; i++) begin
				px = '{rand_radiance(), rand_radiance(), rand_radiance()};
				send_pixel(px, 0, BLACK);
			end
			s_tvalid <= 1'b0;
		end

		// Random body; the first phase uses the reset gain, later phases random gains.
		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			write_gain(ph == 0 ? 16'd2560 : 16'($urandom));
			for (int i = 0; i < 250; i++) begin
				px = '{rand_radiance(), rand_radiance(), rand_radiance()};
				send_pixel(px, 0, BLACK);
			end
			s_tvalid <= 1'b0;
		end

		// Last stretch at full rate on both sides.
		calm = 1'b1;
		for (int i = 0; i < 100; i++) begin
			px = '{rand_radiance(), rand_radiance(), rand_radiance()};
			send_pixel(px, 0, BLACK);
		end
		s_tvalid <= 1'b0;
		wait_idle();

		if (fail_count == 0 && pixel_queue.size() == 0) begin
			$display("exponential_tonemap_pixel_top verification clean");
		end else begin
			$display("exponential_tonemap_pixel_top verification failed");
		end
		$finish;
	end

	// Run limit.
	initial begin
		#(12 * 400000);
		$display("exponential_tonemap_pixel_top verification failed");
		$finish;
	end

endmodule
`default_nettype wire

// File: sim.f
hw/rtl/etm_pkg.sv
hw/rtl/etm_exp.sv
hw/rtl/etm_sqrt.sv
hw/rtl/etm_lane.sv
hw/rtl/exponential_tonemap_pixel_top.sv
tb/sv/tb.sv
